### sv/qvr_pkg.sv
`timescale 1ns / 1ps
package qvr_pkg;

    localparam int CW        = 16;
    localparam int QCW       = 16;
    localparam int PRW       = 2 * QCW;
    localparam int NW        = 2 * QCW + 1;
    localparam int MW        = 2 * QCW + 2;
    localparam int PW        = MW + CW;
    localparam int AW        = PW + 2;
    localparam int QW        = CW + 1;
    localparam int NS        = QW + 5;
    localparam int DW        = ((3 * CW + 7) / 8) * 8;
    localparam int CFG_IDX_W = 4;
    localparam int NCOEF     = 9;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [QCW-1:0] quat_t;
    typedef logic signed [MW-1:0]  coef_t;
    typedef logic [NW-1:0]         norm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X = CFG_IDX_W'(0),
        REG_QUAT_Y = CFG_IDX_W'(1),
        REG_QUAT_Z = CFG_IDX_W'(2),
        REG_QUAT_W = CFG_IDX_W'(3)
    } reg_idx_t;

endpackage

### sv/quaternion_vector_rotation.sv
`timescale 1ns / 1ps
// Rotates a 3-D point by the quaternion held in four configuration registers,
// computing q*p*conj(q) / |q|^2, rounded to nearest and saturated.
// Input stream (s_axis_*): one point per transaction, x/y/z in tdata.
// Output stream (m_axis_*): one rotated point per input transaction, in order;
// tuser carries the clipped and invalid flags.
// Config port: cfg_we/cfg_index/cfg_data writes quat_x, quat_y, quat_z, quat_w
// (index 0..3); other indexes are ignored. Write only while the stream is idle.
// Each point passes through 22 register stages: 5 arithmetic stages plus
// 17 divider stages, one quotient bit per stage.
// Throughput: one point per cycle; every stage holds its own valid bit.
// A stall on m_axis_tready backs up stage by stage; empty stages still fill,
// so the input keeps taking points until the whole pipeline is full.
// Reset clears all valid bits and loads the identity quaternion (w = 1.0).
// An all-zero quaternion gives zero coordinates with invalid set.
module quaternion_vector_rotation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [qvr_pkg::DW-1:0]        s_axis_tdata,  // point_x, point_y, point_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [qvr_pkg::DW-1:0]        m_axis_tdata,  // rotated_x, rotated_y, rotated_z
    output logic [1:0]                    m_axis_tuser,  // clipped, invalid
    input  logic                          cfg_we,
    input  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qvr_pkg::QCW-1:0]       cfg_data
);
    import qvr_pkg::*;

    localparam logic [QW:0] LIM_POS = (QW+1)'(2**(CW-1) - 1);
    localparam logic [QW:0] LIM_NEG = (QW+1)'(2**(CW-1));
    localparam coord_t      CMAX    = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t      CMIN    = {1'b1, {(CW-1){1'b0}}};

    quat_t qx_reg, qy_reg, qz_reg, qw_reg;
    coef_t coef [NCOEF];
    norm_t norm;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    coord_t                st0_p_reg [3];
    coord_t                st1_p_reg [3];
    logic signed [PW-1:0]  st2_prod_reg [NCOEF];
    logic signed [AW-1:0]  sum3 [3];
    logic [AW-1:0]         rem_reg [QW+1][3];
    logic [QW-1:0]         quo_reg [QW+1][3];
    logic                  neg_reg [QW+1][3];

    coord_t out_next [3];
    logic   clip_lane [3];
    coord_t out_reg [3];
    logic   clip_reg;
    logic   inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= QCW'(16384);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_QUAT_X: qx_reg <= cfg_data;
                REG_QUAT_Y: qy_reg <= cfg_data;
                REG_QUAT_Z: qz_reg <= cfg_data;
                REG_QUAT_W: qw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    qvr_coef u_coef (
        .clk  (clk),
        .qx   (qx_reg),
        .qy   (qy_reg),
        .qz   (qz_reg),
        .qw   (qw_reg),
        .coef (coef),
        .norm (norm)
    );

    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // point capture, then one slot while the coefficients settle
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st0_p_reg[0] <= s_axis_tdata[CW-1:0];
            st0_p_reg[1] <= s_axis_tdata[2*CW-1:CW];
            st0_p_reg[2] <= s_axis_tdata[3*CW-1:2*CW];
        end
        if (en[1])
        begin
            st1_p_reg <= st0_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                st2_prod_reg[k] <= PW'(coef[k]) * PW'(st1_p_reg[k % 3]);
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum3[r] = AW'(st2_prod_reg[3*r]) + AW'(st2_prod_reg[3*r+1])
                    + AW'(st2_prod_reg[3*r+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int r = 0; r < 3; r++)
            begin
                neg_reg[0][r] <= sum3[r][AW-1];
                rem_reg[0][r] <= sum3[r][AW-1] ? AW'(-sum3[r]) : AW'(sum3[r]);
                quo_reg[0][r] <= '0;
            end
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar j = 1; j <= QW; j++)
    begin : g_div
        localparam int SH = QW - j;
        logic [AW-1:0] dsub;
        assign dsub = AW'(norm) << SH;

        for (genvar r = 0; r < 3; r++)
        begin : g_lane
            logic ge;
            assign ge = rem_reg[j-1][r] >= dsub;

            always_ff @(posedge clk)
            begin
                if (en[3+j])
                begin
                    neg_reg[j][r] <= neg_reg[j-1][r];
                    rem_reg[j][r] <= ge ? rem_reg[j-1][r] - dsub : rem_reg[j-1][r];
                    quo_reg[j][r] <= {quo_reg[j-1][r][QW-2:0], ge};
                end
            end
        end
    end

    always_comb
    begin
        logic          rnd;
        logic [QW:0]   mag;
        logic [QW:0]   nmag;
        for (int r = 0; r < 3; r++)
        begin
            rnd  = {rem_reg[QW][r], 1'b0} >= (AW+1)'(norm);
            mag  = (QW+1)'(quo_reg[QW][r]) + (QW+1)'(rnd);
            nmag = ~mag + 1'b1;
            if (!neg_reg[QW][r] && mag > LIM_POS)
            begin
                out_next[r]  = CMAX;
                clip_lane[r] = 1'b1;
            end
            else if (neg_reg[QW][r] && mag > LIM_NEG)
            begin
                out_next[r]  = CMIN;
                clip_lane[r] = 1'b1;
            end
            else
            begin
                out_next[r]  = neg_reg[QW][r] ? nmag[CW-1:0] : mag[CW-1:0];
                clip_lane[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            if (norm == '0)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    out_reg[r] <= '0;
                end
                clip_reg <= 1'b0;
                inv_reg  <= 1'b1;
            end
            else
            begin
                out_reg  <= out_next;
                clip_reg <= clip_lane[0] | clip_lane[1] | clip_lane[2];
                inv_reg  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = DW'({out_reg[2], out_reg[1], out_reg[0]});
    assign m_axis_tuser  = {inv_reg, clip_reg};

endmodule

### sv/qvr_coef.sv
`timescale 1ns / 1ps
module qvr_coef (
    input  logic          clk,
    input  qvr_pkg::quat_t qx,
    input  qvr_pkg::quat_t qy,
    input  qvr_pkg::quat_t qz,
    input  qvr_pkg::quat_t qw,
    output qvr_pkg::coef_t coef [qvr_pkg::NCOEF],
    output qvr_pkg::norm_t norm
);
    import qvr_pkg::*;

    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;
    localparam int NPROD = 10;

    logic signed [PRW-1:0] prod_next [NPROD];
    logic signed [PRW-1:0] prod_reg  [NPROD];
    coef_t                 coef_next [NCOEF];
    coef_t                 coef_reg  [NCOEF];
    norm_t                 norm_next;
    norm_t                 norm_reg;

    function automatic coef_t sx(input logic signed [PRW-1:0] a);
        return MW'(a);
    endfunction

    function automatic norm_t ux(input logic signed [PRW-1:0] a);
        return NW'($unsigned(a));
    endfunction

    always_comb
    begin
        prod_next[P_WW] = qw * qw;
        prod_next[P_XX] = qx * qx;
        prod_next[P_YY] = qy * qy;
        prod_next[P_ZZ] = qz * qz;
        prod_next[P_XY] = qx * qy;
        prod_next[P_XZ] = qx * qz;
        prod_next[P_YZ] = qy * qz;
        prod_next[P_WX] = qw * qx;
        prod_next[P_WY] = qw * qy;
        prod_next[P_WZ] = qw * qz;
    end

    always_comb
    begin
        coef_next[0] = sx(prod_reg[P_WW]) + sx(prod_reg[P_XX])
                     - sx(prod_reg[P_YY]) - sx(prod_reg[P_ZZ]);
        coef_next[1] = (sx(prod_reg[P_XY]) - sx(prod_reg[P_WZ])) <<< 1;
        coef_next[2] = (sx(prod_reg[P_XZ]) + sx(prod_reg[P_WY])) <<< 1;
        coef_next[3] = (sx(prod_reg[P_XY]) + sx(prod_reg[P_WZ])) <<< 1;
        coef_next[4] = sx(prod_reg[P_WW]) - sx(prod_reg[P_XX])
                     + sx(prod_reg[P_YY]) - sx(prod_reg[P_ZZ]);
        coef_next[5] = (sx(prod_reg[P_YZ]) - sx(prod_reg[P_WX])) <<< 1;
        coef_next[6] = (sx(prod_reg[P_XZ]) - sx(prod_reg[P_WY])) <<< 1;
        coef_next[7] = (sx(prod_reg[P_YZ]) + sx(prod_reg[P_WX])) <<< 1;
        coef_next[8] = sx(prod_reg[P_WW]) - sx(prod_reg[P_XX])
                     - sx(prod_reg[P_YY]) + sx(prod_reg[P_ZZ]);
        norm_next    = ux(prod_reg[P_WW]) + ux(prod_reg[P_XX])
                     + ux(prod_reg[P_YY]) + ux(prod_reg[P_ZZ]);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        coef_reg <= coef_next;
        norm_reg <= norm_next;
    end

    assign coef = coef_reg;
    assign norm = norm_reg;

endmodule

### sv/qvr_check.sv
`timescale 1ns / 1ps
module qvr_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [qvr_pkg::DW-1:0]        m_axis_tdata,
    input logic [1:0]                    m_axis_tuser
);
    import qvr_pkg::*;

    localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

    coord_t rx, ry, rz;
    assign rx = m_axis_tdata[CW-1:0];
    assign ry = m_axis_tdata[2*CW-1:CW];
    assign rz = m_axis_tdata[3*CW-1:2*CW];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            rx == '0 && ry == '0 && rz == '0 && !m_axis_tuser[0])
        else $error("invalid result carries data");

    a_clip_edge: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            rx == CMAX || rx == CMIN || ry == CMAX || ry == CMIN
            || rz == CMAX || rz == CMIN)
        else $error("clipped set with no saturated coordinate");

    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind quaternion_vector_rotation qvr_check u_qvr_check (.*);
